// ===== hw/rtl/ssmo_pkg.sv =====
// ssmo_pkg: shared constants and the quarter-wave sine table builder
`timescale 1ns / 1ps

package ssmo_pkg;

  // configuration register indexes (byte address 4*i)
  localparam int unsigned CfgAddrBits = 3;
  localparam logic RegPhaseInc = 1'b0;
  localparam logic RegMorph    = 1'b1;

  // Q1.15 one, for the morph blend
  localparam logic [15:0] MorphOne = 16'h8000;
  // output gain 0.3 as Q0.16
  localparam logic signed [15:0] GainQ16 = 16'sd19661;
  // width of the result field
  localparam int unsigned SampleOutW = 15;

  // floor quotient by restoring shift and subtract, used only while building the table
  function automatic longint unsigned div_floor(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // entry k of the quarter sine table, round(amp*sin(pi/2*k/q)) by a Q30 series
  function automatic logic [63:0] quarter_sine(input int unsigned k,
                                               input int unsigned tb,
                                               input int unsigned sb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned amp;
    longint unsigned v;
    longint unsigned dv;
    x   = (longint'(k) * 64'd1686629713) >> (tb - 2);
    x2  = (x * x) >> 30;
    term = x;
    sum  = x;
    amp  = (64'd1 << (sb - 1)) - 64'd1;
    for (int unsigned n = 1; n <= 9; n++) begin
      dv   = longint'(2 * n) * longint'(2 * n + 1);
      term = div_floor((term * x2) >> 30, dv);
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/ssmo_if.sv =====
// ssmo_if: valid/ready channel interfaces for tick items and sample items
`timescale 1ns / 1ps

interface ssmo_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ssmo_sample_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/ssmo_front.sv =====
// ssmo_front: accepts tick items, keeps the phase accumulator, emits table indexes
`timescale 1ns / 1ps

module ssmo_front #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ssmo_tick_if.sink             tick_i,
  input  logic [PHASE_BITS-1:0] phase_inc_i,
  output logic                  push_valid_o,
  output logic [TABLE_BITS-1:0] push_idx_o,
  input  logic                  push_ready_i
);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] phase_now;
  logic                  accept;

  // item taken whenever the queue has room
  assign tick_i.ready = push_ready_i;
  assign accept       = tick_i.valid && push_ready_i;

  // restart zeroes the phase before the sample is formed
  assign phase_now    = tick_i.restart ? '0 : phase_q;
  assign push_valid_o = tick_i.valid;
  assign push_idx_o   = phase_now[PHASE_BITS-1 -: TABLE_BITS];

  // advance after forming the index
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = phase_now + phase_inc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== hw/rtl/ssmo_fifo.sv =====
// ssmo_fifo: two-entry queue of table indexes between front and back
`timescale 1ns / 1ps

module ssmo_fifo #(
  parameter int unsigned DATA_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output logic [DATA_W-1:0] pop_data_o,
  input  logic              pop_ready_i
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wptr_q, wptr_d;
  logic              rptr_q, rptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = ~wptr_q;
    end
    if (do_pop) begin
      rptr_d = ~rptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/ssmo_back.sv =====
// ssmo_back: table lookup, morph blend, gain and rounding pipeline
`timescale 1ns / 1ps

module ssmo_back #(
  parameter int unsigned TABLE_BITS  = 10,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  input  logic [TABLE_BITS-1:0] pop_idx_i,
  output logic                  pop_ready_o,
  input  logic [15:0]           morph_i,
  ssmo_sample_if.source         sample_o
);

  import ssmo_pkg::*;

  localparam int unsigned QLen  = 1 << (TABLE_BITS - 2);
  localparam int unsigned AddrW = TABLE_BITS - 1;
  localparam int unsigned MagW  = SAMPLE_BITS - 1;
  localparam int unsigned ProdW = SAMPLE_BITS + 17;
  localparam int unsigned GainW = ProdW + 16;
  localparam logic signed [SAMPLE_BITS-1:0] Amp = {1'b0, {MagW{1'b1}}};

  // quarter wave plus its end point, fixed at elaboration
  logic [MagW-1:0] qtab [QLen+1];
  for (genvar g = 0; g <= QLen; g++) begin : g_tab
    localparam logic [63:0] Entry = quarter_sine(g, TABLE_BITS, SAMPLE_BITS);
    assign qtab[g] = Entry[MagW-1:0];
  end

  logic                          adv;
  logic                          v1_q, v2_q, v3_q, v4_q, vo_q;
  logic signed [SAMPLE_BITS-1:0] s1_q;
  logic                          sqneg1_q;
  logic signed [ProdW-1:0]       pa2_q, pb2_q;
  logic signed [ProdW-1:0]       acc3_q;
  logic signed [GainW-1:0]       p4_q;
  logic signed [14:0]            sample_q, sample_d;

  // whole pipeline moves unless the result register is held
  assign adv         = !vo_q || sample_o.ready;
  assign pop_ready_o = adv;

  // quadrant mirroring of the table index
  logic [1:0]                    quad;
  logic [TABLE_BITS-3:0]         kidx;
  logic [AddrW-1:0]              taddr;
  logic [MagW-1:0]               tval;
  logic signed [SAMPLE_BITS-1:0] s_d;
  always_comb begin
    quad  = pop_idx_i[TABLE_BITS-1 -: 2];
    kidx  = pop_idx_i[TABLE_BITS-3:0];
    taddr = quad[0] ? (AddrW'(QLen) - {1'b0, kidx}) : {1'b0, kidx};
    tval  = qtab[taddr];
    s_d   = quad[1] ? -$signed({1'b0, tval}) : $signed({1'b0, tval});
  end

  // morph saturated to one, and its complement
  logic [15:0]        m_sat;
  logic [15:0]        m_inv;
  always_comb begin
    m_sat = (morph_i > MorphOne) ? MorphOne : morph_i;
    m_inv = MorphOne - m_sat;
  end

  // round half away from zero to Q1.15
  logic                    neg4;
  logic [GainW-1:0]        mag4;
  logic [GainW-1:0]        rnd4;
  always_comb begin
    neg4     = p4_q[GainW-1];
    mag4     = neg4 ? GainW'(-p4_q) : GainW'(p4_q);
    rnd4     = (mag4 + (GainW'(1) << (SAMPLE_BITS + 14))) >> (SAMPLE_BITS + 15);
    sample_d = neg4 ? $signed(-rnd4[14:0]) : $signed(rnd4[14:0]);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s_d;
      sqneg1_q <= quad[1] && (tval != '0);
      pa2_q    <= s1_q * $signed({1'b0, m_inv});
      pb2_q    <= (sqneg1_q ? -Amp : Amp) * $signed({1'b0, m_sat});
      acc3_q   <= pa2_q + pb2_q;
      p4_q     <= GainW'(acc3_q) * GainW'(GainQ16);
      sample_q <= sample_d;
    end
  end

  assign sample_o.valid      = vo_q;
  assign sample_o.sample_out = sample_q;

endmodule

// ===== hw/rtl/sine_square_morph_oscillator_core.sv =====
// A tick item's table index passes through the index queue and then the pipeline to the sample.
// Throughput: one tick item per cycle while the output is not stalled; the blend and gain pipeline has five stages.
// A two-entry index queue parts the phase front from the pipeline; output backpressure
// holds the pipeline and fills the queue before tick ready drops.
// Reset: asynchronous, active low; clears the phase, both registers and all valid bits.
`timescale 1ns / 1ps

module sine_square_morph_oscillator_core #(
  parameter int unsigned PHASE_BITS  = 32,
  parameter int unsigned TABLE_BITS  = 10,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ssmo_tick_if.sink                         tick_i,
  ssmo_sample_if.source                     sample_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssmo_pkg::CfgAddrBits-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import ssmo_pkg::*;

  logic [31:0]           phase_inc_q;
  logic [15:0]           morph_q;
  logic                  reg_idx;
  logic                  cfg_wr;
  logic [PHASE_BITS+31:0] inc_ext;
  logic [PHASE_BITS-1:0] inc_p;

  logic                  push_valid, push_ready;
  logic [TABLE_BITS-1:0] push_idx;
  logic                  pop_valid, pop_ready;
  logic [TABLE_BITS-1:0] pop_idx;

  // register port decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      morph_q     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegPhaseInc: phase_inc_q <= pwdata;
        RegMorph:    morph_q     <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPhaseInc: prdata = phase_inc_q;
      RegMorph:    prdata = {16'h0000, morph_q};
      default:     prdata = '0;
    endcase
  end

  // increment fitted to the accumulator width
  assign inc_ext = {{PHASE_BITS{1'b0}}, phase_inc_q};
  assign inc_p   = inc_ext[PHASE_BITS-1:0];

  ssmo_front #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_i),
    .phase_inc_i  (inc_p),
    .push_valid_o (push_valid),
    .push_idx_o   (push_idx),
    .push_ready_i (push_ready)
  );

  ssmo_fifo #(
    .DATA_W (TABLE_BITS)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_idx),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_idx),
    .pop_ready_i  (pop_ready)
  );

  ssmo_back #(
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_idx_i   (pop_idx),
    .pop_ready_o (pop_ready),
    .morph_i     (morph_q),
    .sample_o    (sample_o)
  );

endmodule
